// ===== rtl/trp_pkg.sv =====
`timescale 1ns / 1ps

package trp_pkg;

  // mode codes carried on the phase field
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_RECORD = 2'd1;
  localparam logic [1:0] PH_PLAY   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BLINK_PERIOD     = 2'd0;
  localparam logic [1:0] CFG_INACTIVITY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_MAX_EVENTS       = 2'd2;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned IDLE_W      = 16;
  localparam int unsigned MAX_EV_W    = 6;

  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST     = 16'd67;
  localparam logic [IDLE_W-1:0]   INACTIVITY_LIMIT_RST = 16'd800;
  localparam logic [MAX_EV_W-1:0] MAX_EVENTS_RST       = 6'd20;
  localparam logic [IDLE_W-1:0]   IDLE_SAT             = 16'hFFFF;

  localparam int unsigned STORE_DEPTH_DEF = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

endpackage

// ===== rtl/trp_store.sv =====
`timescale 1ns / 1ps

module trp_store #(
  parameter int unsigned STORE_DEPTH = trp_pkg::STORE_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH = trp_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned IDX_W = $clog2(STORE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [IDX_W-1:0]       wr_addr_i,
  input  logic [COUNT_WIDTH-1:0] wr_data_i,
  input  logic [IDX_W-1:0]       rd_addr_i,
  output logic [COUNT_WIDTH-1:0] rd_data_o
);

  logic [COUNT_WIDTH-1:0] mem [STORE_DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/trp_core.sv =====
`timescale 1ns / 1ps

module trp_core #(
  parameter int unsigned STORE_DEPTH = trp_pkg::STORE_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH = trp_pkg::COUNT_WIDTH_DEF,
  localparam int unsigned IDX_W = $clog2(STORE_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          button_i,
  input  logic [trp_pkg::PERIOD_W-1:0]  blink_period_i,
  input  logic [trp_pkg::IDLE_W-1:0]    inactivity_limit_i,
  input  logic [trp_pkg::MAX_EV_W-1:0]  max_events_i,
  input  logic [COUNT_WIDTH-1:0]        rd_data_i,
  output logic [IDX_W-1:0]              rd_addr_o,
  output logic                          wr_en_o,
  output logic [IDX_W-1:0]              wr_addr_o,
  output logic [COUNT_WIDTH-1:0]        wr_data_o,
  output logic                          red_o,
  output logic                          green_o,
  output logic [1:0]                    phase_o
);

  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LIM_W = (CNT_W > trp_pkg::MAX_EV_W) ? CNT_W : trp_pkg::MAX_EV_W;

  logic [1:0]                   phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]       tick_q, tick_d, tick_inc;
  logic [trp_pkg::PERIOD_W-1:0] blink_q, blink_d, blink_dec, blink_nxt;
  logic [CNT_W-1:0]             event_q, event_d;
  logic [IDX_W-1:0]             play_q, play_d;
  logic [trp_pkg::IDLE_W-1:0]   idle_q, idle_d;
  logic                         prev_q, prev_d;
  logic                         red_q, red_d;
  logic                         green_q, green_d;

  logic             fall;
  logic             blink_hit;
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] max_ext;
  logic             exiting;
  logic             last_event;
  logic             match;
  logic             store_ok;

  assign fall      = prev_q & ~button_i;
  assign tick_inc  = tick_q + COUNT_WIDTH'(1);
  assign blink_dec = blink_q - trp_pkg::PERIOD_W'(1);
  assign blink_hit = (blink_dec == '0);
  // period of zero reloads zero, so the next decrement wraps
  assign blink_nxt = blink_hit ? blink_period_i : blink_dec;

  assign max_ext = LIM_W'(max_events_i);
  assign limit   = (max_ext < LIM_W'(STORE_DEPTH)) ? max_ext : LIM_W'(STORE_DEPTH);
  assign exiting = (idle_q >= inactivity_limit_i) || (LIM_W'(event_q) >= limit);

  assign last_event = (CNT_W'(play_q) + CNT_W'(1)) >= event_q;
  assign match      = (tick_inc == rd_data_i);
  assign store_ok   = event_q < CNT_W'(STORE_DEPTH);

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_inc;
    blink_d   = blink_q;
    event_d   = event_q;
    play_d    = play_q;
    idle_d    = idle_q;
    prev_d    = prev_q;
    red_d     = red_q;
    green_d   = green_q;
    wr_en_o   = 1'b0;
    wr_addr_o = event_q[IDX_W-1:0];
    wr_data_o = tick_inc;

    case (phase_q)
      trp_pkg::PH_RECORD: begin
        blink_d = blink_nxt;
        if (blink_hit) begin
          red_d = ~red_q;
        end
        if (exiting) begin
          tick_d  = '0;
          play_d  = '0;
          green_d = 1'b0;
          phase_d = (event_q == '0) ? trp_pkg::PH_IDLE : trp_pkg::PH_PLAY;
        end
        if (idle_q != trp_pkg::IDLE_SAT) begin
          idle_d = idle_q + trp_pkg::IDLE_W'(1);
        end
        // a press on the exit tick is dropped
        if (fall && !exiting && store_ok) begin
          wr_en_o = step_i;
          event_d = event_q + CNT_W'(1);
          idle_d  = '0;
          tick_d  = '0;
          green_d = ~green_q;
        end
        prev_d = button_i;
      end
      trp_pkg::PH_PLAY: begin
        red_d = ~red_q;
        if (match) begin
          if (last_event) begin
            play_d  = '0;
            event_d = '0;
            green_d = 1'b0;
            phase_d = trp_pkg::PH_IDLE;
          end else begin
            green_d = ~green_q;
            play_d  = play_q + IDX_W'(1);
            tick_d  = '0;
          end
        end
      end
      default: begin
        phase_d = trp_pkg::PH_IDLE;
        blink_d = blink_nxt;
        if (blink_hit) begin
          red_d   = ~red_q;
          green_d = ~green_q;
        end
        if (fall) begin
          phase_d = trp_pkg::PH_RECORD;
          tick_d  = '0;
          idle_d  = '0;
        end
        prev_d = button_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= trp_pkg::PH_IDLE;
      tick_q  <= '0;
      blink_q <= trp_pkg::BLINK_PERIOD_RST;
      event_q <= '0;
      play_q  <= '0;
      idle_q  <= '0;
      prev_q  <= 1'b0;
      red_q   <= 1'b0;
      green_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      blink_q <= blink_d;
      event_q <= event_d;
      play_q  <= play_d;
      idle_q  <= idle_d;
      prev_q  <= prev_d;
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  // prefetch the entry the next tick compares against
  assign rd_addr_o = step_i ? play_d : play_q;

  assign red_o   = red_d;
  assign green_o = green_d;
  assign phase_o = phase_d;

endmodule

// ===== rtl/tap_rhythm_record_playback_unit.sv =====
`timescale 1ns / 1ps

// tap rhythm recorder / player, one transfer per timer tick
//
// input channel: in_valid_i / in_stall_o with button_level_i (1 released,
// 0 pressed); each transfer is one tick
// output channel: out_valid_o / out_stall_i with red_led_o, green_led_o and
// phase_o (0 idle, 1 record, 2 playback), one result per tick
// config: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 blink period, 1 inactivity limit, 2 max events); write only while idle
//
// the result of a tick is on the output register in the cycle after its
// transfer; one tick is taken per cycle unless a full result is stalled
// the playback compare reads the interval store through a registered read
// port that is prefetched at the next play index, so no extra cycle is spent
//
// reset loads the blink counter and config with 67 and 67 / 800 / 20, clears
// the mode to idle, both LEDs and all other counters; the interval store is
// not cleared; while out_stall_i holds a full output register, in_stall_o is
// raised and the result stays put; an empty or draining one takes a tick
module tap_rhythm_record_playback_unit #(
  parameter int unsigned STORE_DEPTH = trp_pkg::STORE_DEPTH_DEF,
  parameter int unsigned COUNT_WIDTH = trp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            button_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            red_led_o,
  output logic                            green_led_o,
  output logic [1:0]                      phase_o,
  input  logic                            cfg_we_i,
  input  logic [trp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [trp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);

  // configuration registers
  logic [trp_pkg::PERIOD_W-1:0] blink_period_q;
  logic [trp_pkg::IDLE_W-1:0]   inactivity_limit_q;
  logic [trp_pkg::MAX_EV_W-1:0] max_events_q;

  // output register
  logic       out_valid_q, out_valid_d;
  logic       red_q, green_q;
  logic [1:0] phase_q;

  // core / store hookup
  logic                   accept;
  logic                   red_nxt, green_nxt;
  logic [1:0]             phase_nxt;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr, rd_addr;
  logic [COUNT_WIDTH-1:0] wr_data, rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q     <= trp_pkg::BLINK_PERIOD_RST;
      inactivity_limit_q <= trp_pkg::INACTIVITY_LIMIT_RST;
      max_events_q       <= trp_pkg::MAX_EVENTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trp_pkg::CFG_BLINK_PERIOD:     blink_period_q     <= cfg_data_i;
        trp_pkg::CFG_INACTIVITY_LIMIT: inactivity_limit_q <= cfg_data_i;
        trp_pkg::CFG_MAX_EVENTS:       max_events_q       <= cfg_data_i[trp_pkg::MAX_EV_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // stall only when a finished result is still held by the receiver
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  trp_core #(
    .STORE_DEPTH (STORE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (accept),
    .button_i           (button_level_i),
    .blink_period_i     (blink_period_q),
    .inactivity_limit_i (inactivity_limit_q),
    .max_events_i       (max_events_q),
    .rd_data_i          (rd_data),
    .rd_addr_o          (rd_addr),
    .wr_en_o            (wr_en),
    .wr_addr_o          (wr_addr),
    .wr_data_o          (wr_data),
    .red_o              (red_nxt),
    .green_o            (green_nxt),
    .phase_o            (phase_nxt)
  );

  trp_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload loads only on a tick transfer, so a stalled result holds
  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= red_nxt;
      green_q <= green_nxt;
      phase_q <= phase_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_led_o   = red_q;
  assign green_led_o = green_q;
  assign phase_o     = phase_q;

endmodule

// ===== rtl/trp_checker.sv =====
`timescale 1ns / 1ps

module trp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            red_led_o,
  input logic                            green_led_o,
  input logic [1:0]                      phase_o
);

  logic       out_xfer;
  logic       last_vld_q;
  logic [1:0] last_phase_q;
  logic       last_red_q;

  assign out_xfer = out_valid_o & ~out_stall_i;

  // last result taken by the receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_vld_q   <= 1'b0;
      last_phase_q <= trp_pkg::PH_IDLE;
      last_red_q   <= 1'b0;
    end else if (out_xfer) begin
      last_vld_q   <= 1'b1;
      last_phase_q <= phase_o;
      last_red_q   <= red_led_o;
    end
  end

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_o != 2'd3))
    else $error("phase code 3 on output");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_led_o)
      && $stable(green_led_o) && $stable(phase_o))
    else $error("stalled result changed");

  a_full_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("tick taken while result held");

  a_play_red_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && last_vld_q && last_phase_q == trp_pkg::PH_PLAY
      && phase_o == trp_pkg::PH_PLAY |-> red_led_o != last_red_q)
    else $error("red did not toggle in playback");

  a_idle_no_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && last_vld_q && last_phase_q == trp_pkg::PH_IDLE
      |-> phase_o != trp_pkg::PH_PLAY)
    else $error("idle went straight to playback");

endmodule

bind tap_rhythm_record_playback_unit trp_checker u_trp_checker (.*);
